// ===== hw/rtl/pem_pkg.sv =====
// Shared constants, types and the log fraction table for the peak envelope meter.
package pem_pkg;

  localparam int LANES          = 8;
  localparam int SAMPLE_BITS    = 24;
  localparam int LOG_TABLE_BITS = 6;

  localparam int LOG_TABLE_SIZE = 1 << LOG_TABLE_BITS;
  localparam int POS_BITS       = $clog2(SAMPLE_BITS);
  localparam int LOG_NEG_BITS   = POS_BITS + 16;
  localparam int LOG_SCALE_BITS = 17;
  localparam int LOG_PROD_BITS  = LOG_NEG_BITS + LOG_SCALE_BITS;
  localparam int LOG_DROP_BITS  = LOG_PROD_BITS - 19;

  localparam int IN_BYTES       = (LANES * SAMPLE_BITS + 7) / 8;
  localparam int IN_DATA_BITS   = IN_BYTES * 8;
  localparam int LEVEL_BITS     = 24;
  localparam int METER_BITS     = 16;
  localparam int OUT_DATA_BITS  = LEVEL_BITS + METER_BITS;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int COUNT_BITS     = 4;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

  localparam longint unsigned FULL_SCALE = 64'd1 << (SAMPLE_BITS - 1);
  // Levels at or below this value lie at or under -60 dBFS.
  localparam logic [SAMPLE_BITS-1:0] LOG_FLOOR = SAMPLE_BITS'(FULL_SCALE / 1000);
  localparam logic [POS_BITS-1:0] TOP_POS = POS_BITS'(SAMPLE_BITS - 1);
  // log10(2)/3 in Q20.
  localparam logic [LOG_SCALE_BITS-1:0] LOG_SCALE = LOG_SCALE_BITS'(105218);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DECAY_COEFF   = 2'd0,
    REG_LOG_MODE      = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_UNUSED        = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] decay_coeff;
    logic        log_mode;
  } back_cfg_t;

  typedef logic [15:0] log_tab_t [LOG_TABLE_SIZE];

  // round(log2(m / 2^LOG_TABLE_BITS) * 2^16) by repeated squaring.
  function automatic logic [15:0] frac_log2(input longint unsigned m);
    longint unsigned v;
    longint unsigned r;
    v = m << (30 - LOG_TABLE_BITS);
    r = 0;
    for (int k = 0; k < 17; k++) begin
      v = (v * v) >> 30;
      r = r << 1;
      if (v >= (64'd1 << 31)) begin
        r = r | 64'd1;
        v = v >> 1;
      end
    end
    return 16'((r + 64'd1) >> 1);
  endfunction

  function automatic log_tab_t build_log_table();
    log_tab_t t;
    for (int i = 0; i < LOG_TABLE_SIZE; i++) begin
      t[i] = frac_log2(longint'(LOG_TABLE_SIZE + i));
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TABLE = build_log_table();

endpackage

// ===== hw/rtl/pem_front.sv =====
// Front end: takes frames, forms lane magnitudes and the frame peak.
module pem_front import pem_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [IN_DATA_BITS-1:0] in_data,
  input  logic [COUNT_BITS-1:0]  channel_count,
  output logic                   peak_valid,
  output logic [SAMPLE_BITS-1:0] peak,
  input  logic                   queue_full
);

  logic                   adv;
  logic                   mag_valid;
  logic [SAMPLE_BITS-1:0] mag [LANES];
  logic [SAMPLE_BITS-1:0] mag_next [LANES];
  logic [SAMPLE_BITS-1:0] peak_next;

  assign adv      = !peak_valid || !queue_full;
  assign in_ready = adv;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic [SAMPLE_BITS-1:0] s;
      s = in_data[i*SAMPLE_BITS +: SAMPLE_BITS];
      if (COUNT_BITS'(i) >= channel_count) begin
        mag_next[i] = '0;
      end else if (s[SAMPLE_BITS-1]) begin
        mag_next[i] = -s;
      end else begin
        mag_next[i] = s;
      end
    end
  end

  always_comb begin
    peak_next = '0;
    for (int i = 0; i < LANES; i++) begin
      if (mag[i] > peak_next) begin
        peak_next = mag[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid  <= 1'b0;
      peak_valid <= 1'b0;
    end else if (adv) begin
      mag_valid  <= in_valid;
      peak_valid <= mag_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag  <= mag_next;
      peak <= peak_next;
    end
  end

endmodule

// ===== hw/rtl/pem_queue.sv =====
// Short queue of frame peaks between the front end and the envelope back end.
module pem_queue import pem_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [SAMPLE_BITS-1:0] push_data,
  output logic                   full,
  input  logic                   pop,
  output logic [SAMPLE_BITS-1:0] pop_data,
  output logic                   not_empty
);

  logic [SAMPLE_BITS-1:0] entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QPTR_BITS:0]     count;

  assign full      = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/pem_back.sv =====
// Back end: envelope update loop followed by the linear and decibel meter pipeline.
module pem_back import pem_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  back_cfg_t              cfg,
  input  logic                   peak_avail,
  input  logic [SAMPLE_BITS-1:0] peak,
  output logic                   peak_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_level,
  output logic [METER_BITS-1:0]  out_meter
);

  localparam int LIN_RSH = (SAMPLE_BITS >= 17) ? SAMPLE_BITS - 17 : 0;
  localparam int LIN_LSH = (SAMPLE_BITS < 17) ? 17 - SAMPLE_BITS : 0;
  localparam int LIN_W   = SAMPLE_BITS + 17;
  localparam int NORM_W  = SAMPLE_BITS + LOG_TABLE_BITS;

  logic en;

  // Envelope stage.
  logic                      lvl_valid;
  logic [SAMPLE_BITS-1:0]    level;
  logic [SAMPLE_BITS-1:0]    level_next;
  logic [SAMPLE_BITS-1:0]    diff;
  logic [SAMPLE_BITS+15:0]   rel_prod;
  logic [SAMPLE_BITS+16:0]   rel_sum;

  // Classify stage.
  logic                      b_valid;
  logic [SAMPLE_BITS-1:0]    b_level;
  logic [METER_BITS-1:0]     b_lin;
  logic                      b_small;
  logic [POS_BITS-1:0]       b_pos;
  logic [LIN_W-1:0]          lin_wide;
  logic [METER_BITS-1:0]     lin_next;

  // Table stage.
  logic                      c_valid;
  logic [SAMPLE_BITS-1:0]    c_level;
  logic [METER_BITS-1:0]     c_lin;
  logic                      c_small;
  logic                      c_sat;
  logic [LOG_NEG_BITS-1:0]   c_neg;
  logic [NORM_W-1:0]         norm;
  logic [POS_BITS-1:0]       shamt;
  logic [LOG_TABLE_BITS-1:0] tab_idx;

  // Multiply stage.
  logic                      d_valid;
  logic [SAMPLE_BITS-1:0]    d_level;
  logic [METER_BITS-1:0]     d_lin;
  logic                      d_small;
  logic                      d_sat;
  logic [LOG_PROD_BITS-1:0]  d_prod;

  logic [LOG_PROD_BITS:0]    drop_sum;
  logic [LOG_DROP_BITS-1:0]  drop;
  logic [METER_BITS-1:0]     log_meter;

  function automatic logic [POS_BITS-1:0] lead_one(input logic [SAMPLE_BITS-1:0] v);
    logic [POS_BITS-1:0] p;
    p = '0;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      if (v[i]) begin
        p = POS_BITS'(i);
      end
    end
    return p;
  endfunction

  assign en       = !out_valid || out_ready;
  assign peak_pop = en && peak_avail;

  // Instant attack, otherwise release by the ceiling of coeff*(level-peak)/2^16.
  assign diff     = level - peak;
  assign rel_prod = cfg.decay_coeff * diff;
  assign rel_sum  = {1'b0, rel_prod} + (SAMPLE_BITS+17)'(16'hFFFF);
  always_comb begin
    if (peak > level) begin
      level_next = peak;
    end else begin
      level_next = level - rel_sum[16 +: SAMPLE_BITS];
    end
  end

  assign lin_wide = ({{17{1'b0}}, level} << LIN_LSH) >> LIN_RSH;
  assign lin_next = (lin_wide[LIN_W-1:16] != '0) ? '1 : lin_wide[15:0];

  assign shamt   = TOP_POS - b_pos;
  assign norm    = {b_level, {LOG_TABLE_BITS{1'b0}}} << shamt;
  assign tab_idx = norm[NORM_W-2 -: LOG_TABLE_BITS];

  assign drop_sum = {1'b0, d_prod} + (LOG_PROD_BITS+1)'(20'hFFFFF);
  assign drop     = drop_sum[20 +: LOG_DROP_BITS];

  always_comb begin
    if (d_small) begin
      log_meter = '0;
    end else if (d_sat || drop == '0) begin
      log_meter = '1;
    end else if (drop >= LOG_DROP_BITS'(65536)) begin
      log_meter = '0;
    end else begin
      log_meter = 16'(17'h10000 - drop[16:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      lvl_valid <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      lvl_valid <= peak_avail;
      b_valid   <= lvl_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      out_valid <= d_valid;
      if (peak_avail) begin
        level <= level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_level   <= level;
      b_lin     <= lin_next;
      b_small   <= (level <= LOG_FLOOR);
      b_pos     <= lead_one(level);

      c_level   <= b_level;
      c_lin     <= b_lin;
      c_small   <= b_small;
      c_sat     <= (b_pos == TOP_POS);
      c_neg     <= {shamt, 16'h0000} - LOG_NEG_BITS'(LOG_TABLE[tab_idx]);

      d_level   <= c_level;
      d_lin     <= c_lin;
      d_small   <= c_small;
      d_sat     <= c_sat;
      d_prod    <= c_neg * LOG_SCALE;

      out_level <= d_level;
      out_meter <= cfg.log_mode ? log_meter : d_lin;
    end
  end

endmodule

// ===== hw/rtl/peak_envelope_meter_core.sv =====
// Peak envelope meter: one frame in, one level and meter value out, per clock unless stalled.
// Throughput, while the output is not stalled, is one frame per cycle, set by the envelope
// update loop (one 24x16 multiply, round and subtract each cycle). A four-entry peak queue
// decouples front and back.
// Reset clears the envelope level, all pipeline valids and the configuration registers.
module peak_envelope_meter_core import pem_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,  // sample_0 .. sample_7, 24 bits each
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,  // level_out[23:0], meter[39:24]
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  back_cfg_t              back_cfg;
  logic [COUNT_BITS-1:0]  channel_count;
  logic                   peak_valid;
  logic [SAMPLE_BITS-1:0] front_peak;
  logic                   queue_full;
  logic                   queue_push;
  logic                   queue_pop;
  logic                   queue_avail;
  logic [SAMPLE_BITS-1:0] queue_peak;
  logic [SAMPLE_BITS-1:0] level;
  logic [METER_BITS-1:0]  meter;
  cfg_reg_t               reg_sel;

  assign cfg_ready = 1'b1;
  assign reg_sel   = cfg_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      back_cfg      <= '0;
      channel_count <= '0;
    end else if (cfg_valid) begin
      unique case (reg_sel)
        REG_DECAY_COEFF:   back_cfg.decay_coeff <= cfg_data;
        REG_LOG_MODE:      back_cfg.log_mode    <= cfg_data[0];
        REG_CHANNEL_COUNT: channel_count        <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign queue_push = peak_valid && !queue_full;

  pem_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_data       (s_axis_tdata),
    .channel_count (channel_count),
    .peak_valid    (peak_valid),
    .peak          (front_peak),
    .queue_full    (queue_full)
  );

  pem_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (queue_push),
    .push_data (front_peak),
    .full      (queue_full),
    .pop       (queue_pop),
    .pop_data  (queue_peak),
    .not_empty (queue_avail)
  );

  pem_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (back_cfg),
    .peak_avail (queue_avail),
    .peak       (queue_peak),
    .peak_pop   (queue_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_level  (level),
    .out_meter  (meter)
  );

  assign m_axis_tdata = {meter, LEVEL_BITS'(level)};

endmodule

// ===== tb/sv/peak_envelope_meter_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the peak envelope meter core with its own envelope predictor.
module peak_envelope_meter_core_test;
  import pem_pkg::*;

  // Cycles to let pass after the last reading before the configuration is touched.
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_PHASES = 14;
  localparam int FRAMES_PER_PHASE = 125;

  typedef logic [LANES-1:0][SAMPLE_BITS-1:0] frame_t;

  typedef enum int {
    MIX_FULL,
    MIX_SCALED,
    MIX_SILENT,
    MIX_EXTREME,
    MIX_QUIET
  } frame_mix_t;

  // Tracks the envelope and meter value exactly as the core should, one frame at a time.
  class envelope_tracker;
    localparam int FRAC_BITS = 6;
    localparam longint unsigned FULL_SCALE_LEVEL = 64'd1 << 23;
    localparam longint unsigned DB_PER_OCTAVE_Q20 = 105218;

    typedef struct {
      logic [23:0] level;
      logic [15:0] meter;
    } reading_t;

    logic [15:0] coeff;
    logic        db_scale;
    logic [3:0]  lanes_on;
    longint unsigned level;
    longint unsigned frac_log [1 << FRAC_BITS];
    reading_t    pending [$];
    int          failures;

    function new();
      for (int i = 0; i < (1 << FRAC_BITS); i++) begin
        frac_log[i] = log2_fraction(longint'((1 << FRAC_BITS) + i));
      end
      coeff = '0;
      db_scale = 1'b0;
      lanes_on = '0;
      level = 0;
      failures = 0;
    endfunction

    // Fractional log2 of m / 2^FRAC_BITS in Q16, bit by bit through repeated squaring.
    function longint unsigned log2_fraction(longint unsigned m);
      longint unsigned v;
      longint unsigned bits;
      v = m << (30 - FRAC_BITS);
      bits = 0;
      for (int k = 0; k < 17; k++) begin
        v = (v * v) >> 30;
        bits = bits << 1;
        if (v >= (64'd1 << 31)) begin
          bits = bits | 64'd1;
          v = v >> 1;
        end
      end
      return (bits + 64'd1) >> 1;
    endfunction

    function void apply_write(cfg_reg_t idx, logic [15:0] val);
      case (idx)
        REG_DECAY_COEFF: coeff = val;
        REG_LOG_MODE: db_scale = val[0];
        REG_CHANNEL_COUNT: lanes_on = val[3:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] meter_of(longint unsigned lvl);
      longint unsigned idx;
      longint unsigned n;
      longint unsigned drop;
      longint signed lg;
      int top;
      if (!db_scale) begin
        n = lvl >> 7;
        return (n > 65535) ? 16'hFFFF : 16'(n);
      end
      // At or below -60 dBFS the meter reads zero.
      if (lvl * 1000 <= FULL_SCALE_LEVEL) return 16'd0;
      top = 0;
      while (top < 63 && (lvl >> (top + 1)) != 0) top++;
      if (top >= FRAC_BITS) idx = (lvl >> (top - FRAC_BITS)) & ((1 << FRAC_BITS) - 1);
      else idx = (lvl << (FRAC_BITS - top)) & ((1 << FRAC_BITS) - 1);
      lg = longint'(top - 23) * 65536 + longint'(frac_log[idx]);
      if (lg >= 0) return 16'hFFFF;
      n = -lg;
      drop = (n * DB_PER_OCTAVE_Q20 + ((64'd1 << 20) - 1)) >> 20;
      if (drop >= 65536) return 16'd0;
      n = 65536 - drop;
      return (n > 65535) ? 16'hFFFF : 16'(n);
    endfunction

    function void note_frame(frame_t f);
      int active;
      int i;
      longint unsigned peak;
      longint unsigned mag;
      logic [23:0] s;
      reading_t r;
      active = (lanes_on > LANES) ? LANES : int'(lanes_on);
      peak = 0;
      for (i = 0; i < active; i++) begin
        s = f[i];
        mag = s[23] ? ((64'd1 << 24) - s) : s;
        if (mag > peak) peak = mag;
      end
      if (peak > level) level = peak;
      else level = level - ((coeff * (level - peak) + 65535) >> 16);
      r.level = 24'(level);
      r.meter = meter_of(level);
      pending.push_back(r);
    endfunction

    function void check_reading(logic [OUT_DATA_BITS-1:0] d);
      reading_t r;
      if (pending.size() == 0) begin
        failures++;
        $display("%0t: unexpected reading, expected none, actual level %0d meter %0d",
                 $time, d[23:0], d[39:24]);
        return;
      end
      r = pending.pop_front();
      if (d[23:0] !== r.level) begin
        failures++;
        $display("%0t: level mismatch, expected %0d actual %0d", $time, r.level, d[23:0]);
      end
      if (d[39:24] !== r.meter) begin
        failures++;
        $display("%0t: meter mismatch, expected %0d actual %0d", $time, r.meter, d[39:24]);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_DATA_BITS-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  envelope_tracker board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  peak_envelope_meter_core u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("** peak_envelope_meter_core: FAILED **");
    $finish;
  end

  // Result side: checks every transaction and stalls at random or for a requested stretch.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) board.check_reading(m_axis_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic frame_t uniform_frame(logic [SAMPLE_BITS-1:0] v);
    frame_t f;
    for (int i = 0; i < LANES; i++) f[i] = v;
    return f;
  endfunction

  function automatic frame_t random_frame(frame_mix_t mix);
    frame_t f;
    int unsigned pick;
    for (int i = 0; i < LANES; i++) begin
      case (mix)
        MIX_FULL: f[i] = SAMPLE_BITS'($urandom);
        MIX_SCALED: f[i] = SAMPLE_BITS'($signed($urandom) >>> $urandom_range(8, 30));
        MIX_SILENT: f[i] = '0;
        MIX_EXTREME: begin
          pick = $urandom_range(0, 4);
          case (pick)
            0: f[i] = 24'h800000;
            1: f[i] = 24'h7FFFFF;
            2: f[i] = 24'h000001;
            3: f[i] = 24'hFFFFFF;
            default: f[i] = '0;
          endcase
        end
        default: f[i] = SAMPLE_BITS'(int'($urandom_range(0, 18000)) - 9000);
      endcase
    end
    return f;
  endfunction

  task automatic send_frame(input frame_t f);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_DATA_BITS'(f);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_frame(f);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.apply_write(idx, val);
  endtask

  // Waits for the core to drain, then writes all three registers.
  task automatic set_config(input logic [15:0] coeff, input logic mode,
                            input logic [3:0] count, input bit junk_upper);
    logic [14:0] mode_upper;
    logic [11:0] count_upper;
    mode_upper = junk_upper ? 15'($urandom) : 15'd0;
    count_upper = junk_upper ? 12'($urandom) : 12'd0;
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_DECAY_COEFF, coeff);
    write_reg(REG_LOG_MODE, {mode_upper, mode});
    write_reg(REG_CHANNEL_COUNT, {count_upper, count});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    frame_t f;
    frame_mix_t mix;
    int run_left;
    int pick;
    logic [15:0] coeff;
    logic [3:0] count;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_DECAY_COEFF;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The spare register index must be ignored.
    write_reg(REG_UNUSED, 16'hA5C3);
    cfg_valid <= 1'b0;

    // Instant attack to both full-scale extremes, then a hold with a zero coefficient.
    set_config(16'd0, 1'b0, 4'd8, 1'b0);
    send_frame(uniform_frame(24'h7FFFFF));
    send_frame(uniform_frame(24'h800000));
    send_frame(uniform_frame(24'h000000));
    f = uniform_frame(24'h000010);
    f[7] = 24'h85EE00;
    send_frame(f);
    send_frame(uniform_frame(24'h000001));

    // Fastest release, decibel scale, lane count beyond the lane total.
    set_config(16'hFFFF, 1'b1, 4'd15, 1'b0);
    send_frame(uniform_frame(24'h000000));
    send_frame(uniform_frame(24'h800000));
    send_frame(uniform_frame(24'h7FFFFF));
    send_frame(uniform_frame(24'd8389));
    send_frame(uniform_frame(24'd8388));
    send_frame(uniform_frame(24'hFFFFFF));

    // No active lanes: the level only decays.
    set_config(16'h8000, 1'b1, 4'd0, 1'b0);
    repeat (3) send_frame(random_frame(MIX_FULL));

    // One lane, slowest nonzero release; the other lanes are ignored.
    set_config(16'd1, 1'b0, 4'd1, 1'b0);
    f = uniform_frame(24'h800000);
    f[0] = 24'd100;
    send_frame(f);
    f[0] = 24'hFFFF00;
    send_frame(f);
    send_frame(uniform_frame(24'h000000));

    set_config(16'hFFFF, 1'b0, 4'd9, 1'b0);
    send_frame(uniform_frame(24'h800000));
    send_frame(uniform_frame(24'h000000));

    run_left = 0;
    mix = MIX_FULL;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: coeff = 16'd0;
        1: coeff = 16'hFFFF;
        2: coeff = 16'd1;
        default: coeff = 16'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0) count = 4'($urandom_range(0, 15));
      else count = 4'($urandom_range(1, 8));
      set_config(coeff, 1'($urandom), count, 1'($urandom));
      if (ph < 5) begin
        send_idle_pct = 23;
        recv_idle_pct = 70;
      end else if (ph < 10) begin
        send_idle_pct = 70;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // A long result stall while frames keep coming fills the core and backs up its input.
      if (ph == 11) hold_left = 400;
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        if (run_left == 0) begin
          pick = $urandom_range(0, 9);
          if (pick < 4) mix = MIX_FULL;
          else if (pick < 7) mix = MIX_SCALED;
          else if (pick == 7) mix = MIX_SILENT;
          else if (pick == 8) mix = MIX_EXTREME;
          else mix = MIX_QUIET;
          run_left = $urandom_range(1, 20);
        end
        run_left--;
        send_frame(random_frame(mix));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0) begin
      $display("** peak_envelope_meter_core: PASSED **");
    end else begin
      $display("** peak_envelope_meter_core: FAILED **");
    end
    $finish;
  end

endmodule
